[hdl/upr_pkg.sv]
// Shared types and constants for the ultrasonic ping ranger.
`timescale 1ns / 1ps
package upr_pkg;

    // Sequencer phases, one-hot encoded.
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LOW     = 6'b000010,
        PH_HIGH    = 6'b000100,
        PH_CLEAR   = 6'b001000,
        PH_RISE    = 6'b010000,
        PH_MEASURE = 6'b100000
    } t_phase;

    // Widths of the counters and fields.
    localparam int TICK_W  = 16;
    localparam int ELAP_W  = TICK_W + 1;
    localparam int LIMIT_W = 15;
    localparam int CM_W    = 9;
    localparam int DIST_W  = 8;

    // Trigger pulse shape in ticks.
    localparam logic [ELAP_W-1:0] LOW_TICKS  = ELAP_W'(4);
    localparam logic [ELAP_W-1:0] HIGH_TICKS = ELAP_W'(10);

    // Echo limit arithmetic: min(cm, 500) * 57 + 57 / 2.
    localparam logic [CM_W-1:0]    MAX_CM      = CM_W'(500);
    localparam int                 US_PER_CM   = 57;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(500 * US_PER_CM + US_PER_CM / 2);

    // Distance conversion: (ticks - 5) / 146 by reciprocal multiply.
    localparam logic [ELAP_W-1:0] OVERHEAD  = ELAP_W'(5);
    localparam int                US_PER_IN = 146;
    localparam int                DIV_SHIFT = 23;
    localparam int                MULT_W    = 16;
    localparam logic [MULT_W-1:0] DIV_MULT  =
        MULT_W'(((1 << DIV_SHIFT) + US_PER_IN - 1) / US_PER_IN);
    localparam int                PROD_W    = ELAP_W + MULT_W;

    // One result transaction.
    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic              no_echo;
        logic [DIST_W-1:0] distance_in;
    } t_result;

endpackage

[hdl/upr_ctrl.sv]
// Ping sequencer: trigger timing, echo wait, echo timing and distance conversion.
`timescale 1ns / 1ps
module upr_ctrl
    import upr_pkg::*;
#(
    parameter int START_TIMEOUT = 18000
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_start_req,
    input  logic            i_echo_level,
    input  logic            i_cfg_we,
    input  logic [CM_W-1:0] i_cfg_wdata,
    output t_result         o_result
);

    localparam logic [ELAP_W-1:0] START_LIMIT = ELAP_W'(START_TIMEOUT);

    t_phase               r_phase, n_phase;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [LIMIT_W-1:0]   r_cfg_limit;
    logic [CM_W-1:0]      cfg_cm;
    logic [ELAP_W-1:0]    elapsed;
    logic [ELAP_W-1:0]    echo_ticks;
    logic [PROD_W-1:0]    dist_prod;
    t_result              res;

    // The echo limit is worked out as the register is written.
    always_comb begin
        cfg_cm = (i_cfg_wdata > MAX_CM) ? MAX_CM : i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_cfg_limit <= LIMIT_W'(LIMIT_W'(cfg_cm) * LIMIT_W'(US_PER_CM))
                           + LIMIT_W'(US_PER_CM / 2);
        end
    end

    // Echo length less the fixed overhead, then divided by 146.
    always_comb begin
        elapsed    = ELAP_W'(r_tick) + ELAP_W'(1);
        echo_ticks = (elapsed > OVERHEAD) ? (elapsed - OVERHEAD) : '0;
        dist_prod  = PROD_W'(echo_ticks) * PROD_W'(DIV_MULT);
    end

    // Next state and result for the current tick.
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_limit = r_limit;
        res     = '{trigger_level: 1'b0, busy_res: 1'b1, done_res: 1'b0,
                    no_echo: 1'b0, distance_in: '0};
        case (r_phase)
            PH_LOW: begin
                if (elapsed >= LOW_TICKS) begin
                    n_phase = PH_HIGH;
                    n_tick  = '0;
                end else begin
                    n_tick = elapsed[TICK_W-1:0];
                end
            end
            PH_HIGH: begin
                res.trigger_level = 1'b1;
                if (elapsed >= HIGH_TICKS) begin
                    n_phase = PH_CLEAR;
                    n_tick  = '0;
                end else begin
                    n_tick = elapsed[TICK_W-1:0];
                end
            end
            PH_CLEAR: begin
                if (elapsed > START_LIMIT) begin
                    res.done_res = 1'b1;
                    res.no_echo  = 1'b1;
                    n_phase      = PH_IDLE;
                    n_tick       = '0;
                end else begin
                    if (!i_echo_level) begin
                        n_phase = PH_RISE;
                    end
                    n_tick = elapsed[TICK_W-1:0];
                end
            end
            PH_RISE: begin
                if (elapsed > START_LIMIT) begin
                    res.done_res = 1'b1;
                    res.no_echo  = 1'b1;
                    n_phase      = PH_IDLE;
                    n_tick       = '0;
                end else if (i_echo_level) begin
                    n_phase = PH_MEASURE;
                    n_tick  = '0;
                end else begin
                    n_tick = elapsed[TICK_W-1:0];
                end
            end
            PH_MEASURE: begin
                if (!i_echo_level) begin
                    res.done_res    = 1'b1;
                    res.distance_in = dist_prod[DIV_SHIFT +: DIST_W];
                    n_phase         = PH_IDLE;
                    n_tick          = '0;
                end else if (elapsed > ELAP_W'(r_limit)) begin
                    res.done_res = 1'b1;
                    res.no_echo  = 1'b1;
                    n_phase      = PH_IDLE;
                    n_tick       = '0;
                end else begin
                    n_tick = elapsed[TICK_W-1:0];
                end
            end
            default: begin
                // Idle, and any unexpected code behaves as idle.
                n_phase = PH_IDLE;
                n_tick  = '0;
                if (i_start_req) begin
                    n_limit = r_cfg_limit;
                    n_phase = PH_LOW;
                    n_tick  = TICK_W'(1);
                end else begin
                    res.busy_res = 1'b0;
                end
            end
        endcase
    end

    // State advances once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_limit <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_limit <= n_limit;
        end
    end

    assign o_result = res;

endmodule

[hdl/ultrasonic_ping_ranger.sv]
// Top level of the ultrasonic ping ranger with its output register and skid entry.
`timescale 1ns / 1ps
// Each input transaction is one microsecond tick carrying the start request and the
// sampled echo level, and it yields exactly one result transaction. The block takes
// one transaction per clock while the input is not stalled; the per-tick sequencer
// step and the divide-by-146 multiply sit between the accepted inputs and the output
// register. An output register plus one skid entry lets a new transaction enter while
// a finished result waits; input stall rises only once both are full. The distance
// limit register may be written only while no ping runs.
module ultrasonic_ping_ranger
    import upr_pkg::*;
#(
    parameter int START_TIMEOUT = 18000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CM_W-1:0]   i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_start_req,
    input  logic              i_echo_level,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_trigger_level,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic              o_no_echo,
    output logic [DIST_W-1:0] o_distance_in
);

    logic    accept_in;
    logic    out_free;
    t_result step_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    assign accept_in = i_in_valid & ~r_skid_valid;
    assign out_free  = ~r_out_valid | ~i_out_stall;

    upr_ctrl #(
        .START_TIMEOUT(START_TIMEOUT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept_in),
        .i_start_req (i_start_req),
        .i_echo_level(i_echo_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (step_res)
    );

    // Output register and skid entry control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept_in;
            end
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept_in) begin
                r_out <= step_res;
            end
        end else if (accept_in) begin
            r_skid <= step_res;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_out.trigger_level;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_no_echo       = r_out.no_echo;
    assign o_distance_in   = r_out.distance_in;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the ultrasonic ping ranger, with a tick-level predictor.
`timescale 1ns / 1ps
module testbench;
    import upr_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_HALF          = 2;
    localparam int RESET_CYCLES      = 10;
    localparam int DRAIN_GUARD       = 8;
    localparam int RANDOM_PING_TICKS = 1900;
    localparam int LONG_HOLD_CYCLES  = 60;

    // Ping timing and distance arithmetic, in ticks.
    localparam int TRIG_LOW_LEN     = 4;
    localparam int TRIG_HIGH_LEN    = 10;
    localparam int TRIG_TICKS       = TRIG_LOW_LEN + TRIG_HIGH_LEN;
    localparam int START_WAIT_LIMIT = 18000;
    localparam int RANGE_CAP_CM     = 500;
    localparam int TICKS_PER_CM     = 57;
    localparam int TICKS_PER_INCH   = 146;
    localparam int ECHO_OFFSET      = 5;

    // A directed row with this range leaves the register as it is.
    localparam int KEEP_RANGE = -1;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [CM_W-1:0]   cfg_wdata  = '0;
    logic              in_valid   = 1'b0;
    logic              start_req  = 1'b0;
    logic              echo_level = 1'b0;
    logic              rx_stall   = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic              no_echo;
    logic [DIST_W-1:0] distance_in;

    // Idling controls for the sender and the receiver.
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    int rx_hold_len = 0;

    int ping_ticks = 0;
    int err_count  = 0;

    // Expected result transactions, oldest first.
    t_result pending_results[$];

    // Predicted ranger state and distance limit register.
    t_phase             ph       = PH_IDLE;
    logic [TICK_W-1:0]  tick_cnt = '0;
    logic [LIMIT_W-1:0] echo_lim = '0;
    logic [CM_W-1:0]    range_cm = CM_W'(RANGE_CAP_CM);

    // One directed ping: echo pattern after the trigger and the expected outcome.
    typedef struct {
        int cm;
        int lead;
        int stuck;
        int low_len;
        int high_len;
        bit busy_start;
        bit typed;
        bit exp_no_echo;
        int exp_dist;
    } ping_row_t;

    localparam int NUM_ROWS = 19;

    // Range, idle lead, stuck high, low, high, starts while busy, typed, no echo, inches.
    ping_row_t ping_table [NUM_ROWS] = '{
        '{500,        3, 0,     1,     5,     0, 1, 0, 0},
        '{KEEP_RANGE, 0, 0,     1,     4,     0, 1, 0, 0},
        '{KEEP_RANGE, 0, 0,     1,     1,     1, 1, 0, 0},
        '{KEEP_RANGE, 0, 2,     3,     150,   0, 1, 0, 0},
        '{KEEP_RANGE, 0, 0,     2,     151,   1, 1, 0, 1},
        '{KEEP_RANGE, 1, 5,     1,     297,   0, 1, 0, 2},
        '{0,          0, 0,     1,     29,    0, 1, 0, 0},
        '{KEEP_RANGE, 0, 0,     1,     30,    0, 1, 1, 0},
        '{1,          0, 0,     1,     86,    0, 1, 0, 0},
        '{KEEP_RANGE, 0, 0,     1,     87,    1, 1, 1, 0},
        '{250,        0, 3,     7,     5000,  0, 0, 0, 0},
        '{501,        0, 1,     1,     28529, 0, 1, 0, 195},
        '{511,        0, 0,     1,     28530, 0, 1, 1, 0},
        '{KEEP_RANGE, 0, 20000, 0,     0,     0, 1, 1, 0},
        '{KEEP_RANGE, 0, 0,     20000, 0,     1, 1, 1, 0},
        '{KEEP_RANGE, 0, 100,   17899, 151,   0, 1, 0, 1},
        '{KEEP_RANGE, 0, 100,   17900, 151,   0, 1, 1, 0},
        '{300,        2, 0,     40,    9000,  1, 0, 0, 0},
        '{500,        0, 0,     1,     14000, 0, 0, 0, 0}
    };

    ultrasonic_ping_ranger dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_start_req     (start_req),
        .i_echo_level    (echo_level),
        .o_out_valid     (out_valid),
        .i_out_stall     (rx_stall),
        .o_trigger_level (trigger_level),
        .o_busy_res      (busy_res),
        .o_done_res      (done_res),
        .o_no_echo       (no_echo),
        .o_distance_in   (distance_in)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Advance the predicted ranger by one tick and return that tick's result.
    function automatic t_result next_tick_result(input bit start, input bit echo);
        t_result            res;
        logic [ELAP_W-1:0]  elapsed;
        logic [CM_W-1:0]    cm_eff;
        res          = '0;
        res.busy_res = 1'b1;
        elapsed      = ELAP_W'(tick_cnt) + 1'b1;
        case (ph)
            PH_LOW: begin
                if (elapsed >= TRIG_LOW_LEN) begin
                    ph       = PH_HIGH;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = elapsed[TICK_W-1:0];
                end
            end
            PH_HIGH: begin
                res.trigger_level = 1'b1;
                if (elapsed >= TRIG_HIGH_LEN) begin
                    ph       = PH_CLEAR;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = elapsed[TICK_W-1:0];
                end
            end
            PH_CLEAR, PH_RISE: begin
                // The start timeout spans the clear and rise waits and beats the echo.
                if (elapsed > START_WAIT_LIMIT) begin
                    res.done_res = 1'b1;
                    res.no_echo  = 1'b1;
                    ph           = PH_IDLE;
                    tick_cnt     = '0;
                end else if (ph == PH_CLEAR) begin
                    if (!echo) ph = PH_RISE;
                    tick_cnt = elapsed[TICK_W-1:0];
                end else if (echo) begin
                    ph       = PH_MEASURE;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = elapsed[TICK_W-1:0];
                end
            end
            PH_MEASURE: begin
                // A falling echo is always a distance; the limit applies while high.
                if (!echo) begin
                    res.done_res = 1'b1;
                    if (elapsed > ECHO_OFFSET) begin
                        res.distance_in = DIST_W'((elapsed - ECHO_OFFSET) / TICKS_PER_INCH);
                    end
                    ph       = PH_IDLE;
                    tick_cnt = '0;
                end else if (elapsed > echo_lim) begin
                    res.done_res = 1'b1;
                    res.no_echo  = 1'b1;
                    ph           = PH_IDLE;
                    tick_cnt     = '0;
                end else begin
                    tick_cnt = elapsed[TICK_W-1:0];
                end
            end
            default: begin
                ph       = PH_IDLE;
                tick_cnt = '0;
                if (start) begin
                    cm_eff   = (range_cm > RANGE_CAP_CM) ? CM_W'(RANGE_CAP_CM) : range_cm;
                    echo_lim = LIMIT_W'(int'(cm_eff) * TICKS_PER_CM + TICKS_PER_CM / 2);
                    ph       = PH_LOW;
                    tick_cnt = TICK_W'(1);
                end else begin
                    res.busy_res = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    // Offer one tick transaction, hold it until accepted, then record its result.
    task automatic send_tick(input bit start, input bit echo, input bit typed_en,
                             input bit typed_ne, input int typed_dist,
                             output t_result res);
        if (tx_idle_en && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= start;
        echo_level <= echo;
        do @(posedge clk); while (in_stall);
        res = next_tick_result(start, echo);
        // Directed rows with an obvious outcome carry their own expected finish.
        if (typed_en && res.done_res) begin
            res.no_echo     = typed_ne;
            res.distance_in = DIST_W'(typed_dist);
        end
        pending_results.push_back(res);
    endtask

    // Ticks with no start request and a random echo level.
    task automatic idle_ticks(input int n);
        t_result res;
        repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 0, res);
    endtask

    // One full ping: start, trigger, then the echo pattern until the ping finishes.
    task automatic run_ping(input int stuck, input int low_len, input int high_len,
                            input bit busy_start, input bit typed_en, input bit typed_ne,
                            input int typed_dist);
        t_result res;
        int      k;
        int      idx;
        bit      start;
        bit      echo;
        k = 0;
        do begin
            idx = k - TRIG_TICKS;
            if (idx < 0) begin
                echo = 1'($urandom_range(0, 1));
            end else begin
                echo = (idx < stuck) ||
                       (idx >= stuck + low_len && idx < stuck + low_len + high_len);
            end
            start = (k == 0) || busy_start || ($urandom_range(0, 3) == 0);
            send_tick(start, echo, typed_en, typed_ne, typed_dist, res);
            k++;
        end while (!res.done_res);
        ping_ticks += k;
    endtask

    // Write the range register once the block is idle and every result is back.
    task automatic write_range_cm(input int cm);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= CM_W'(cm);
        @(posedge clk);
        cfg_we   <= 1'b0;
        range_cm  = CM_W'(cm);
    endtask

    task automatic flag_field(input string field, input logic [DIST_W-1:0] want_v,
                              input logic [DIST_W-1:0] seen_v);
        if (seen_v !== want_v) begin
            err_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want_v, seen_v);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold when requested.
    initial begin
        int hold;
        forever begin
            if (rx_hold_len > 0) begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                rx_stall   <= 1'b1;
                repeat (hold) @(posedge clk);
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                rx_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                rx_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    initial begin
        t_result want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !rx_stall) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result with nothing expected, done %0b dist %0d",
                             $time, done_res, distance_in);
                end else begin
                    want = pending_results.pop_front();
                    flag_field("trigger_level", DIST_W'(want.trigger_level),
                               DIST_W'(trigger_level));
                    flag_field("busy_res", DIST_W'(want.busy_res), DIST_W'(busy_res));
                    flag_field("done_res", DIST_W'(want.done_res), DIST_W'(done_res));
                    flag_field("no_echo", DIST_W'(want.no_echo), DIST_W'(no_echo));
                    flag_field("distance_in", want.distance_in, distance_in);
                end
            end
        end
    end

    // Main sequence: reset, directed pings, random pings, then drain.
    initial begin
        int r;
        int pick;
        int stuck;
        int low_len;
        int high_len;
        bit hold_done;
        hold_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pings from the table.
        for (r = 0; r < NUM_ROWS; r++) begin
            if (ping_table[r].cm != KEEP_RANGE) write_range_cm(ping_table[r].cm);
            idle_ticks(ping_table[r].lead);
            run_ping(ping_table[r].stuck, ping_table[r].low_len, ping_table[r].high_len,
                     ping_table[r].busy_start, ping_table[r].typed,
                     ping_table[r].exp_no_echo, ping_table[r].exp_dist);
            idle_ticks(1);
        end

        // Random pings, range changes and idle noise.
        ping_ticks = 0;
        while (ping_ticks < RANDOM_PING_TICKS) begin
            if (ping_ticks > RANDOM_PING_TICKS * 3 / 4) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (!hold_done && ping_ticks > RANDOM_PING_TICKS / 3) begin
                // Hold the receiver off while the sender keeps the input full.
                hold_done   = 1'b1;
                tx_idle_en  = 1'b0;
                rx_hold_len = LONG_HOLD_CYCLES;
                run_ping(0, 2, 80, 1'b0, 1'b0, 1'b0, 0);
                tx_idle_en  = 1'b1;
            end else if (pick < 8) begin
                case ($urandom_range(0, 6))
                    0:       write_range_cm(0);
                    1:       write_range_cm(1);
                    2:       write_range_cm(499);
                    3:       write_range_cm(500);
                    4:       write_range_cm(501);
                    5:       write_range_cm(511);
                    default: write_range_cm($urandom_range(0, 511));
                endcase
            end else if (pick < 20) begin
                idle_ticks($urandom_range(1, 6));
            end else begin
                stuck   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
                low_len = $urandom_range(1, 8);
                pick    = $urandom_range(0, 99);
                if (pick < 85)      high_len = $urandom_range(1, 30);
                else if (pick < 98) high_len = $urandom_range(100, 450);
                else                high_len = $urandom_range(450, 2000);
                run_ping(stuck, low_len, high_len, $urandom_range(0, 7) == 0,
                         1'b0, 1'b0, 0);
                idle_ticks($urandom_range(0, 2));
            end
        end

        // Let every outstanding result arrive, then allow for stragglers.
        in_valid  <= 1'b0;
        rx_idle_en = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_GUARD) @(posedge clk);
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
